>>> rtl/crbfc_pkg.sv
// Package for the credit buffer flow controller: command codes and payload types.
package crbfc_pkg;

  typedef enum logic [3:0] {
    CMD_CHECK_SEND      = 4'd0,
    CMD_ACQUIRE         = 4'd1,
    CMD_RELEASE         = 4'd2,
    CMD_THRESHOLD_CHECK = 4'd3,
    CMD_UPDATE_BUFFER   = 4'd4,
    CMD_PAUSE           = 4'd5,
    CMD_RESUME          = 4'd6,
    CMD_RECORD_RECEIVED = 4'd7,
    CMD_RESET           = 4'd8
  } cmd_t;

  localparam logic REG_START_CREDITS = 1'b0;
  localparam logic REG_WINDOW_SIZE   = 1'b1;

  localparam logic [31:0] START_CREDITS_RESET = 32'd10;
  localparam logic [31:0] WINDOW_SIZE_RESET   = 32'd1048576;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] byte_count;
    logic [31:0] credit_count;
    logic [31:0] buffer_amount;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] credits_now;
    logic [31:0] buffer_now;
    logic        paused_now;
    logic [47:0] sent_total;
    logic [47:0] received_total;
  } out_item_t;

endpackage

>>> rtl/credit_buffer_flow_controller_core.sv
// Credit buffer flow controller: credit and buffer accounting with a skid-buffered result.
// A result is registered into the output stage, or into the skid stage while the output stalls.
// Throughput: one item per cycle while the skid stage is empty; state updates and the result are computed in one pass.
// in_ready depends only on the skid register, so an item is taken while a result waits.
// Reset (rst, synchronous): credits 10, buffer 1048576, flag and totals cleared,
// registers back to their reset values, output and skid stages empty.
module credit_buffer_flow_controller_core
  import crbfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] start_credits;
  logic [31:0] window_size;

  logic [31:0] credit_reg, credit_next;
  logic [31:0] buffer_reg, buffer_next;
  logic        pause_flag, pause_next;
  logic [47:0] sent_count, sent_next;
  logic [47:0] received_count, received_next;
  logic        granted_next;

  logic        skid_valid;
  out_item_t   skid_data;
  out_item_t   result;

  logic        in_fire;
  logic        out_fire;
  logic        may_send;
  logic [32:0] credit_sum;
  logic [32:0] buffer_sum;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign may_send   = !pause_flag && (credit_reg != 32'd0) &&
                      (buffer_reg >= in_data.byte_count);
  assign credit_sum = {1'b0, credit_reg} + {1'b0, in_data.credit_count};
  assign buffer_sum = {1'b0, buffer_reg} + {1'b0, in_data.buffer_amount};

  always_comb begin
    credit_next   = credit_reg;
    buffer_next   = buffer_reg;
    pause_next    = pause_flag;
    sent_next     = sent_count;
    received_next = received_count;
    granted_next  = 1'b0;
    case (in_data.cmd)
      CMD_CHECK_SEND: begin
        granted_next = may_send;
      end
      CMD_ACQUIRE: begin
        if (may_send) begin
          granted_next = 1'b1;
          credit_next  = credit_reg - 32'd1;
          buffer_next  = buffer_reg - in_data.byte_count;
          sent_next    = sent_count + {16'd0, in_data.byte_count};
        end
      end
      CMD_RELEASE: begin
        // sums are formed without wrap, then saturated at the window
        credit_next = (credit_sum > {1'b0, window_size}) ? window_size : credit_sum[31:0];
        buffer_next = (buffer_sum > {1'b0, window_size}) ? window_size : buffer_sum[31:0];
      end
      CMD_THRESHOLD_CHECK: begin
        granted_next = (credit_reg >= in_data.credit_count) &&
                       (buffer_reg >= in_data.byte_count);
      end
      CMD_UPDATE_BUFFER: begin
        buffer_next = (in_data.buffer_amount < window_size) ? in_data.buffer_amount
                                                            : window_size;
      end
      CMD_PAUSE: begin
        pause_next = 1'b1;
      end
      CMD_RESUME: begin
        pause_next = 1'b0;
      end
      CMD_RECORD_RECEIVED: begin
        received_next = received_count + {16'd0, in_data.byte_count};
      end
      CMD_RESET: begin
        credit_next   = window_size >> 1;
        buffer_next   = window_size;
        sent_next     = 48'd0;
        received_next = 48'd0;
        pause_next    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.granted        = granted_next;
    result.credits_now    = credit_next;
    result.buffer_now     = buffer_next;
    result.paused_now     = pause_next;
    result.sent_total     = sent_next;
    result.received_total = received_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_credits  <= START_CREDITS_RESET;
      window_size    <= WINDOW_SIZE_RESET;
      credit_reg     <= START_CREDITS_RESET;
      buffer_reg     <= WINDOW_SIZE_RESET;
      pause_flag     <= 1'b0;
      sent_count     <= 48'd0;
      received_count <= 48'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_START_CREDITS) begin
          start_credits <= cfg_data;
        end else if (cfg_index == REG_WINDOW_SIZE) begin
          window_size <= cfg_data;
        end
      end
      if (in_fire) begin
        credit_reg     <= credit_next;
        buffer_reg     <= buffer_next;
        pause_flag     <= pause_next;
        sent_count     <= sent_next;
        received_count <= received_next;
      end
    end
  end

  // start_credits is not used; block reset loads the constant START_CREDITS_RESET into the credit count
  logic unused_start;
  assign unused_start = ^start_credits;

  // output register plus skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else if (in_fire) begin
          out_data  <= result;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (in_fire) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output stage is empty");

  a_pause_set: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.cmd == CMD_PAUSE) |=> pause_flag)
    else $error("pause command did not set the flag");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.cmd == CMD_RESET) |=> (sent_count == 48'd0 &&
      received_count == 48'd0 && !pause_flag))
    else $error("reset command did not clear totals");

  a_out_fire_drains: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !skid_valid && !in_fire) |=> !out_valid)
    else $error("output stage kept a taken item");

endmodule

>>> tb/tb.sv
// Testbench for credit_buffer_flow_controller_core: queued driver, checking monitor, predictor.
`timescale 1ns / 1ps

module tb;
  import crbfc_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int NUM_PHASES       = 8;
  localparam int RANDOM_PER_PHASE = 90;
  localparam int UNUSED_CMD_MIN   = 9;
  localparam int UNUSED_CMD_MAX   = 15;
  localparam int MAX_REPORTS      = 40;
  localparam longint TIMEOUT_NS   = 64'd2_400_000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = REG_START_CREDITS;
  logic [31:0] cfg_data  = '0;

  credit_buffer_flow_controller_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor copy of the block's registers and state
  logic [31:0] mdl_start_credits;
  logic [31:0] mdl_window;
  logic [31:0] mdl_credits;
  logic [31:0] mdl_buffer;
  logic        mdl_paused;
  logic [47:0] mdl_sent;
  logic [47:0] mdl_recv;

  in_item_t  pending_cmds[$];
  out_item_t expected_status[$];

  int   n_pushed     = 0;
  int   n_accepted   = 0;
  int   n_results    = 0;
  int   n_grants     = 0;
  int   n_errors     = 0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic in_taken     = 1'b0;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b, logic [31:0] lim);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, lim}) ? lim : s[31:0];
  endfunction

  function automatic out_item_t flow_ctl_step(in_item_t it);
    out_item_t r;
    logic      may_send;
    r        = '0;
    may_send = !mdl_paused && mdl_credits != 32'd0 && mdl_buffer >= it.byte_count;
    case (it.cmd)
      CMD_CHECK_SEND: r.granted = may_send;
      CMD_ACQUIRE: begin
        if (may_send) begin
          r.granted   = 1'b1;
          mdl_credits = mdl_credits - 32'd1;
          mdl_buffer  = mdl_buffer - it.byte_count;
          mdl_sent    = mdl_sent + {16'd0, it.byte_count};
        end
      end
      CMD_RELEASE: begin
        mdl_credits = sat_add32(mdl_credits, it.credit_count, mdl_window);
        mdl_buffer  = sat_add32(mdl_buffer, it.buffer_amount, mdl_window);
      end
      CMD_THRESHOLD_CHECK: begin
        r.granted = mdl_credits >= it.credit_count && mdl_buffer >= it.byte_count;
      end
      CMD_UPDATE_BUFFER: begin
        mdl_buffer = (it.buffer_amount < mdl_window) ? it.buffer_amount : mdl_window;
      end
      CMD_PAUSE:  mdl_paused = 1'b1;
      CMD_RESUME: mdl_paused = 1'b0;
      CMD_RECORD_RECEIVED: mdl_recv = mdl_recv + {16'd0, it.byte_count};
      CMD_RESET: begin
        mdl_credits = mdl_window >> 1;
        mdl_buffer  = mdl_window;
        mdl_paused  = 1'b0;
        mdl_sent    = '0;
        mdl_recv    = '0;
      end
      default: ;
    endcase
    r.credits_now    = mdl_credits;
    r.buffer_now     = mdl_buffer;
    r.paused_now     = mdl_paused;
    r.sent_total     = mdl_sent;
    r.received_total = mdl_recv;
    return r;
  endfunction

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // monitor: predicts on input acceptance, checks on output acceptance
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      mdl_start_credits = START_CREDITS_RESET;
      mdl_window        = WINDOW_SIZE_RESET;
      mdl_credits       = START_CREDITS_RESET;
      mdl_buffer        = WINDOW_SIZE_RESET;
      mdl_paused        = 1'b0;
      mdl_sent          = '0;
      mdl_recv          = '0;
      in_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_START_CREDITS) mdl_start_credits = cfg_data;
        else mdl_window = cfg_data;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (out_data.granted) n_grants++;
        if (expected_status.size() == 0) begin
          n_errors++;
          $display("%0t: result with none expected, expected nothing, got 0x%0h",
                   $time, out_data);
        end else begin
          want = expected_status.pop_front();
          check_field("granted", 48'(want.granted), 48'(out_data.granted));
          check_field("credits_now", 48'(want.credits_now), 48'(out_data.credits_now));
          check_field("buffer_now", 48'(want.buffer_now), 48'(out_data.buffer_now));
          check_field("paused_now", 48'(want.paused_now), 48'(out_data.paused_now));
          check_field("sent_total", want.sent_total, out_data.sent_total);
          check_field("received_total", want.received_total, out_data.received_total);
        end
      end
      if (in_valid && in_ready) begin
        expected_status = {expected_status, flow_ctl_step(in_data)};
        n_accepted++;
      end
      in_taken <= in_valid && in_ready;
    end
  end

  // driver: holds an item until taken, then launches the next one unless idling
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
      if (!in_valid || in_taken) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_data  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic in_item_t mk(logic [3:0] c, logic [31:0] b, logic [31:0] cr,
                                  logic [31:0] am);
    in_item_t it;
    it.cmd           = c;
    it.byte_count    = b;
    it.credit_count  = cr;
    it.buffer_amount = am;
    return it;
  endfunction

  // amounts cluster around the window edges and small values so grants stay common
  function automatic logic [31:0] pick_amount(logic [31:0] win);
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      2:       v = $urandom;
      3:       v = win;
      4:       v = win - 32'd1;
      5:       v = win + 32'd1;
      default: v = $urandom_range(win >> 3);
    endcase
    return v;
  endfunction

  function automatic in_item_t random_cmd(logic [31:0] win);
    in_item_t it;
    int       r;
    it.byte_count    = pick_amount(win);
    it.credit_count  = pick_amount(win);
    it.buffer_amount = pick_amount(win);
    r = $urandom_range(99);
    if (r < 10)      it.cmd = CMD_CHECK_SEND;
    else if (r < 35) it.cmd = CMD_ACQUIRE;
    else if (r < 50) it.cmd = CMD_RELEASE;
    else if (r < 60) it.cmd = CMD_THRESHOLD_CHECK;
    else if (r < 67) it.cmd = CMD_UPDATE_BUFFER;
    else if (r < 71) it.cmd = CMD_PAUSE;
    else if (r < 79) it.cmd = CMD_RESUME;
    else if (r < 89) it.cmd = CMD_RECORD_RECEIVED;
    else if (r < 93) it.cmd = CMD_RESET;
    else             it.cmd = 4'($urandom_range(UNUSED_CMD_MAX, UNUSED_CMD_MIN));
    return it;
  endfunction

  task automatic queue_cmd(in_item_t it);
    pending_cmds = {pending_cmds, it};
    n_pushed++;
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (n_accepted != n_pushed || expected_status.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    logic [31:0] win;
    logic [31:0] start;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed pass at reset settings, no idling
    win = WINDOW_SIZE_RESET;
    queue_cmd(mk(CMD_CHECK_SEND, '0, '0, '0));
    queue_cmd(mk(CMD_CHECK_SEND, win, '0, '0));
    queue_cmd(mk(CMD_CHECK_SEND, win + 32'd1, '0, '0));
    queue_cmd(mk(CMD_ACQUIRE, win, '0, '0));
    queue_cmd(mk(CMD_ACQUIRE, 32'd1, '0, '0));
    queue_cmd(mk(CMD_ACQUIRE, '0, '0, '0));
    queue_cmd(mk(CMD_RELEASE, '0, '1, '1));    // saturates both counts
    queue_cmd(mk(CMD_THRESHOLD_CHECK, '1, '1, '0));
    queue_cmd(mk(CMD_THRESHOLD_CHECK, win, win, '0));
    queue_cmd(mk(CMD_UPDATE_BUFFER, '0, '0, '1));
    queue_cmd(mk(CMD_UPDATE_BUFFER, '0, '0, '0));
    queue_cmd(mk(CMD_UPDATE_BUFFER, '0, '0, 32'h0005_A5A5));
    queue_cmd(mk(CMD_PAUSE, '0, '0, '0));
    queue_cmd(mk(CMD_CHECK_SEND, '0, '0, '0));
    queue_cmd(mk(CMD_ACQUIRE, '0, '0, '0));
    queue_cmd(mk(CMD_THRESHOLD_CHECK, '0, '0, '0));  // pause has no effect here
    queue_cmd(mk(CMD_RESUME, '0, '0, '0));
    queue_cmd(mk(CMD_RECORD_RECEIVED, '1, '0, '0));
    queue_cmd(mk(CMD_RECORD_RECEIVED, '1, '0, '0));
    queue_cmd(mk(CMD_ACQUIRE, 32'h0005_A5A5, '0, '0));
    queue_cmd(mk(CMD_RESET, '0, '0, '0));
    queue_cmd(mk(4'(UNUSED_CMD_MIN), '1, '1, '1));
    queue_cmd(mk(4'(UNUSED_CMD_MAX), '1, '1, '1));

    for (int p = 1; p <= NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        1:       begin win = 32'd1;         start = '0;            end
        2:       begin win = '1;            start = '1;            end
        3:       begin win = '0;            start = '0;            end
        4:       begin win = 32'd64;        start = 32'd5;         end
        5:       begin win = 32'd4096;      start = $urandom;      end
        6:       begin win = WINDOW_SIZE_RESET; start = START_CREDITS_RESET; end
        7:       begin win = 32'd2;         start = 32'd1;         end
        default: begin win = $urandom;      start = $urandom;      end
      endcase
      write_reg(REG_START_CREDITS, start);
      write_reg(REG_WINDOW_SIZE, win);
      @(negedge clk);
      cfg_we <= 1'b0;
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      if (p == 1) begin
        // buffer left above the new window, then a reset leaves no credits
        queue_cmd(mk(CMD_CHECK_SEND, '0, '0, '0));
        queue_cmd(mk(CMD_RESET, '0, '0, '0));
        queue_cmd(mk(CMD_CHECK_SEND, '0, '0, '0));
        queue_cmd(mk(CMD_THRESHOLD_CHECK, '0, '0, '0));
        queue_cmd(mk(CMD_RELEASE, '0, 32'd1, 32'd1));
        queue_cmd(mk(CMD_ACQUIRE, 32'd1, '0, '0));
        queue_cmd(mk(CMD_ACQUIRE, '0, '0, '0));
      end else if ($urandom_range(1)) begin
        queue_cmd(mk(CMD_RESET, $urandom, $urandom, $urandom));
      end
      repeat (RANDOM_PER_PHASE) queue_cmd(random_cmd(win));
    end

    wait_idle();
    repeat (4) @(negedge clk);
    $display("Ran %0d commands over %0d register settings with four idle patterns.",
             n_accepted, NUM_PHASES + 1);
    $display("Checked %0d results, %0d of them granted, %0d field mismatches.",
             n_results, n_grants, n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still expected.", expected_status.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> credit_buffer_flow_controller_core.f
rtl/crbfc_pkg.sv
rtl/credit_buffer_flow_controller_core.sv
tb/tb.sv
